// ----- hw/rtl/v3a_pkg.sv -----
// ----------------------------------------------------------------------------
// Vector arithmetic unit package
// Shared types, widths and fixed-point helpers for the Q16.16 vector unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int Q_W            = 32;
  localparam int FRAC_BITS      = 16;
  localparam int LANES          = 3;
  localparam int PROD_W         = 2 * Q_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int S_TDATA_W      = 7 * Q_W;
  localparam int S_TUSER_W      = 4;
  localparam int M_TDATA_W      = 4 * Q_W;
  localparam int M_TUSER_W      = 2;
  localparam int DIV_NUM_W      = Q_W + FRAC_BITS;
  localparam int DIV_DEN_W      = Q_W + 1;
  localparam int RAD_W          = PROD_W;
  localparam int SQRT_ROOT_W    = Q_W;
  localparam int MAG_W          = Q_W + 1;
  localparam int DIV_STEPS_DEF  = 4;
  localparam int SQRT_STEPS_DEF = 4;

  localparam logic signed [SUM_W-1:0] Q_MAX_W  = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] Q_MIN_W  = SUM_W'(32'sh8000_0000);
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(2 ** (FRAC_BITS - 1));

  typedef enum logic [3:0] {
    FN_ADD,
    FN_SUB,
    FN_NEG,
    FN_SCALE,
    FN_DIV,
    FN_CROSS,
    FN_DOT,
    FN_PROJ,
    FN_NORM,
    FN_MAG
  } func_e;

  typedef struct packed {
    logic           ovf;
    logic [Q_W-1:0] val;
  } sat_t;

  typedef struct packed {
    func_e                    func;
    logic [LANES-1:0][Q_W-1:0] a;
    logic [LANES-1:0][Q_W-1:0] b;
    logic [Q_W-1:0]           s;
    logic [LANES-1:0][Q_W-1:0] r;
    logic [Q_W-1:0]           rs;
    logic [Q_W-1:0]           pm;
    logic [MAG_W-1:0]         mag;
    logic [LANES-1:0]         neg;
    logic                     ovf;
    logic                     err;
  } ctx_t;

  function automatic sat_t sat_q16(input logic signed [SUM_W-1:0] v);
    sat_t res;
    if (v > Q_MAX_W) begin
      res.ovf = 1'b1;
      res.val = Q_MAX_W[Q_W-1:0];
    end else if (v < Q_MIN_W) begin
      res.ovf = 1'b1;
      res.val = Q_MIN_W[Q_W-1:0];
    end else begin
      res.ovf = 1'b0;
      res.val = v[Q_W-1:0];
    end
    return res;
  endfunction

  // Round a Q32.32 value to nearest Q16.16, ties toward positive infinity.
  function automatic logic signed [SUM_W-1:0] rnd_q16(input logic signed [SUM_W-1:0] v);
    return (v + RND_HALF) >>> FRAC_BITS;
  endfunction

endpackage

// ----- hw/rtl/v3a_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined square root
// Digit-by-digit integer square root, rounded to nearest, several bits a stage.
// ----------------------------------------------------------------------------
module v3a_sqrt #(
  parameter int STEPS = v3a_pkg::SQRT_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [v3a_pkg::RAD_W-1:0]  rad_i,
  output logic [v3a_pkg::MAG_W-1:0]  mag_o
);
  import v3a_pkg::*;

  localparam int STAGES = (SQRT_ROOT_W + STEPS - 1) / STEPS;
  localparam int W      = STAGES * STEPS;
  localparam int RW     = W + 2;
  localparam int RADW   = 2 * W;

  logic [RW-1:0]   rem_q  [STAGES];
  logic [W-1:0]    root_q [STAGES];
  logic [RADW-1:0] rad_q  [STAGES];
  logic [W:0]      root_x;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [RW-1:0]   rem_in;
    logic [W-1:0]    root_in;
    logic [RADW-1:0] rad_in;
    logic [RW-1:0]   rem_nx;
    logic [W-1:0]    root_nx;
    logic [RADW-1:0] rad_nx;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = RADW'(rad_i);
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
    end

    always_comb begin
      logic [RW-1:0] rem_t;
      logic [RW-1:0] trial;
      rem_nx  = rem_in;
      root_nx = root_in;
      rad_nx  = rad_in;
      for (int k = 0; k < STEPS; k++) begin
        rem_t = {rem_nx[RW-3:0], rad_nx[RADW-1 -: 2]};
        trial = {root_nx, 2'b01};
        if (rem_t >= trial) begin
          rem_nx  = rem_t - trial;
          root_nx = {root_nx[W-2:0], 1'b1};
        end else begin
          rem_nx  = rem_t;
          root_nx = {root_nx[W-2:0], 1'b0};
        end
        rad_nx = {rad_nx[RADW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_nx;
        root_q[g] <= root_nx;
        rad_q[g]  <= rad_nx;
      end
    end
  end

  assign root_x = {1'b0, root_q[STAGES-1]}
                + (W+1)'(rem_q[STAGES-1] > {2'b00, root_q[STAGES-1]});
  assign mag_o  = root_x[MAG_W-1:0];

endmodule

// ----- hw/rtl/v3a_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division, several quotient bits a stage.
// ----------------------------------------------------------------------------
module v3a_div #(
  parameter int STEPS = v3a_pkg::DIV_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [v3a_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [v3a_pkg::DIV_DEN_W-1:0] den_i,
  output logic [v3a_pkg::DIV_NUM_W-1:0] quo_o
);
  import v3a_pkg::*;

  localparam int STAGES = (DIV_NUM_W + STEPS - 1) / STEPS;
  localparam int NP     = STAGES * STEPS;
  localparam int RW     = DIV_DEN_W + 1;

  logic [RW-1:0]        rem_q [STAGES];
  logic [NP-1:0]        num_q [STAGES];
  logic [NP-1:0]        quo_q [STAGES];
  logic [DIV_DEN_W-1:0] den_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [RW-1:0]        rem_in;
    logic [NP-1:0]        num_in;
    logic [NP-1:0]        quo_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [RW-1:0]        rem_nx;
    logic [NP-1:0]        num_nx;
    logic [NP-1:0]        quo_nx;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = NP'(num_i);
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign num_in = num_q[g-1];
      assign quo_in = quo_q[g-1];
      assign den_in = den_q[g-1];
    end

    always_comb begin
      logic [RW-1:0] rem_t;
      rem_nx = rem_in;
      num_nx = num_in;
      quo_nx = quo_in;
      for (int k = 0; k < STEPS; k++) begin
        rem_t = {rem_nx[RW-2:0], num_nx[NP-1]};
        if (rem_t >= {1'b0, den_in}) begin
          rem_nx = rem_t - {1'b0, den_in};
          quo_nx = {quo_nx[NP-2:0], 1'b1};
        end else begin
          rem_nx = rem_t;
          quo_nx = {quo_nx[NP-2:0], 1'b0};
        end
        num_nx = {num_nx[NP-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_nx;
        num_q[g] <= num_nx;
        quo_q[g] <= quo_nx;
        den_q[g] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[STAGES-1][DIV_NUM_W-1:0];

endmodule

// ----- hw/rtl/vector3_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Three-component vector arithmetic unit
// Q16.16 vector add, subtract, negate, scale, divide, cross, dot, project,
// normalize and magnitude on a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The unit accepts one transaction every clock cycle unless the output stalls.
// Every operation passes through the square root pipeline followed by the
// divider pipeline. When the result is not taken, the whole pipeline holds
// and s_axis_tready goes low in the same cycle.
module vector3_arithmetic_unit #(
  parameter int DIV_STEPS  = v3a_pkg::DIV_STEPS_DEF,
  parameter int SQRT_STEPS = v3a_pkg::SQRT_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // ax, ay, az, bx, by, bz, scale_value.
  input  logic [v3a_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // func.
  input  logic [v3a_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // rx, ry, rz, rscalar.
  output logic [v3a_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // div_error, overflow.
  output logic [v3a_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import v3a_pkg::*;

  localparam int SQ_STAGES = (SQRT_ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int DV_STAGES = (DIV_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int MULTS     = 2 * LANES;

  logic ce;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic [SQ_STAGES-1:0] vsq_q;
  logic [DV_STAGES-1:0] vdv_q;

  ctx_t c1_d, c1_q, c2_q, c3_q, c4_d, c4_q, c5_d, c5_q, c6_d, c6_q;
  ctx_t c7_d, c7_q, c8_q, c9_d, c9_q;
  ctx_t dsq_q [SQ_STAGES];
  ctx_t ddv_q [DV_STAGES];

  logic signed [Q_W-1:0]    x_d [MULTS];
  logic signed [Q_W-1:0]    y_d [MULTS];
  logic signed [Q_W-1:0]    x_q [MULTS];
  logic signed [Q_W-1:0]    y_q [MULTS];
  logic signed [PROD_W-1:0] p_q [MULTS];
  logic signed [SUM_W-1:0]  sum_d [LANES];
  logic signed [SUM_W-1:0]  sum_q [LANES];
  logic signed [Q_W:0]      e_d [LANES];
  logic signed [Q_W:0]      e_q [LANES];
  logic [RAD_W-1:0]         rad_q;
  logic [MAG_W-1:0]         mag_w;
  logic [DIV_NUM_W-1:0]     nm_d [LANES];
  logic [DIV_NUM_W-1:0]     nm_q [LANES];
  logic [DIV_DEN_W-1:0]     dn_d [LANES];
  logic [DIV_DEN_W-1:0]     dn_q [LANES];
  logic [DIV_NUM_W-1:0]     quo_w [LANES];
  logic signed [PROD_W-1:0] pf_d [LANES];
  logic signed [PROD_W-1:0] pf_q [LANES];

  assign ce            = !v9_q || m_axis_tready;
  assign s_axis_tready = ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      vsq_q <= '0;
      vdv_q <= '0;
    end else if (ce) begin
      v1_q     <= s_axis_tvalid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      vsq_q[0] <= v4_q;
      for (int k = 1; k < SQ_STAGES; k++) begin
        vsq_q[k] <= vsq_q[k-1];
      end
      v5_q     <= vsq_q[SQ_STAGES-1];
      v6_q     <= v5_q;
      vdv_q[0] <= v6_q;
      for (int k = 1; k < DV_STAGES; k++) begin
        vdv_q[k] <= vdv_q[k-1];
      end
      v7_q <= vdv_q[DV_STAGES-1];
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_comb begin
    c1_d      = '0;
    c1_d.func = func_e'(s_axis_tuser);
    for (int i = 0; i < LANES; i++) begin
      c1_d.a[i] = s_axis_tdata[i*Q_W +: Q_W];
      c1_d.b[i] = s_axis_tdata[(LANES+i)*Q_W +: Q_W];
    end
    c1_d.s = s_axis_tdata[2*LANES*Q_W +: Q_W];
    for (int k = 0; k < MULTS; k++) begin
      x_d[k] = '0;
      y_d[k] = '0;
    end
    unique case (c1_d.func) inside
      FN_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          x_d[i] = c1_d.a[i];
          y_d[i] = c1_d.s;
        end
      end
      FN_CROSS: begin
        x_d[0] = c1_d.a[1]; y_d[0] = c1_d.b[2];
        x_d[1] = c1_d.a[2]; y_d[1] = c1_d.b[1];
        x_d[2] = c1_d.a[2]; y_d[2] = c1_d.b[0];
        x_d[3] = c1_d.a[0]; y_d[3] = c1_d.b[2];
        x_d[4] = c1_d.a[0]; y_d[4] = c1_d.b[1];
        x_d[5] = c1_d.a[1]; y_d[5] = c1_d.b[0];
      end
      FN_DOT, FN_PROJ: begin
        for (int i = 0; i < LANES; i++) begin
          x_d[i]       = c1_d.a[i];
          y_d[i]       = c1_d.b[i];
          x_d[LANES+i] = c1_d.b[i];
          y_d[LANES+i] = c1_d.b[i];
        end
      end
      FN_NORM, FN_MAG: begin
        for (int i = 0; i < LANES; i++) begin
          x_d[i] = c1_d.a[i];
          y_d[i] = c1_d.a[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum_d[i] = '0;
      e_d[i]   = '0;
    end
    unique case (c2_q.func) inside
      FN_ADD: begin
        for (int i = 0; i < LANES; i++) begin
          e_d[i] = (Q_W+1)'($signed(c2_q.a[i])) + (Q_W+1)'($signed(c2_q.b[i]));
        end
      end
      FN_SUB: begin
        for (int i = 0; i < LANES; i++) begin
          e_d[i] = (Q_W+1)'($signed(c2_q.a[i])) - (Q_W+1)'($signed(c2_q.b[i]));
        end
      end
      FN_NEG: begin
        for (int i = 0; i < LANES; i++) begin
          e_d[i] = -(Q_W+1)'($signed(c2_q.a[i]));
        end
      end
      FN_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          sum_d[i] = SUM_W'(p_q[i]);
        end
      end
      FN_CROSS: begin
        for (int i = 0; i < LANES; i++) begin
          sum_d[i] = SUM_W'(p_q[2*i]) - SUM_W'(p_q[2*i+1]);
        end
      end
      FN_DOT, FN_PROJ, FN_NORM, FN_MAG: begin
        sum_d[0] = SUM_W'(p_q[0]) + SUM_W'(p_q[1]) + SUM_W'(p_q[2]);
        sum_d[1] = SUM_W'(p_q[3]) + SUM_W'(p_q[4]) + SUM_W'(p_q[5]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sat_t sr [LANES];
    sat_t se [LANES];
    c4_d     = c3_q;
    c4_d.r   = '0;
    c4_d.rs  = '0;
    c4_d.pm  = '0;
    c4_d.ovf = 1'b0;
    c4_d.err = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      sr[i] = sat_q16(rnd_q16(sum_q[i]));
      se[i] = sat_q16(SUM_W'(e_q[i]));
    end
    unique case (c3_q.func) inside
      FN_ADD, FN_SUB, FN_NEG: begin
        for (int i = 0; i < LANES; i++) begin
          c4_d.r[i] = se[i].val;
          c4_d.ovf  = c4_d.ovf | se[i].ovf;
        end
      end
      FN_SCALE, FN_CROSS: begin
        for (int i = 0; i < LANES; i++) begin
          c4_d.r[i] = sr[i].val;
          c4_d.ovf  = c4_d.ovf | sr[i].ovf;
        end
      end
      FN_DOT: begin
        c4_d.rs  = sr[0].val;
        c4_d.ovf = sr[0].ovf;
      end
      FN_PROJ: begin
        c4_d.rs  = sr[0].val;
        c4_d.pm  = sr[1].val;
        c4_d.ovf = sr[0].ovf | sr[1].ovf;
      end
      default: begin
      end
    endcase
  end

  v3a_sqrt #(
    .STEPS (SQRT_STEPS)
  ) u_sqrt (
    .clk_i (clk_i),
    .en_i  (ce),
    .rad_i (rad_q),
    .mag_o (mag_w)
  );

  always_comb begin
    c5_d     = dsq_q[SQ_STAGES-1];
    c5_d.mag = mag_w;
  end

  always_comb begin
    logic [Q_W-1:0] aabs [LANES];
    logic [Q_W-1:0] sabs;
    logic [Q_W-1:0] dabs;
    c6_d = c5_q;
    sabs = c5_q.s[Q_W-1] ? (~c5_q.s + 1'b1) : c5_q.s;
    dabs = c5_q.rs[Q_W-1] ? (~c5_q.rs + 1'b1) : c5_q.rs;
    for (int i = 0; i < LANES; i++) begin
      aabs[i]     = c5_q.a[i][Q_W-1] ? (~c5_q.a[i] + 1'b1) : c5_q.a[i];
      nm_d[i]     = '0;
      dn_d[i]     = '0;
      c6_d.neg[i] = 1'b0;
    end
    unique case (c5_q.func) inside
      FN_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          nm_d[i]     = {aabs[i], {FRAC_BITS{1'b0}}};
          dn_d[i]     = {1'b0, sabs};
          c6_d.neg[i] = c5_q.a[i][Q_W-1] ^ c5_q.s[Q_W-1];
        end
        c6_d.err = (c5_q.s == '0);
      end
      FN_NORM: begin
        for (int i = 0; i < LANES; i++) begin
          nm_d[i]     = {aabs[i], {FRAC_BITS{1'b0}}};
          dn_d[i]     = c5_q.mag;
          c6_d.neg[i] = c5_q.a[i][Q_W-1];
        end
        c6_d.err = (c5_q.mag == '0);
      end
      FN_PROJ: begin
        nm_d[0]     = {dabs, {FRAC_BITS{1'b0}}};
        dn_d[0]     = {1'b0, c5_q.pm};
        c6_d.neg[0] = c5_q.rs[Q_W-1];
        c6_d.err    = (c5_q.pm == '0);
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    v3a_div #(
      .STEPS (DIV_STEPS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (ce),
      .num_i (nm_q[i]),
      .den_i (dn_q[i]),
      .quo_o (quo_w[i])
    );
  end

  always_comb begin
    logic signed [SUM_W-1:0] qv;
    sat_t sq [LANES];
    sat_t sm;
    c7_d = ddv_q[DV_STAGES-1];
    for (int i = 0; i < LANES; i++) begin
      qv    = SUM_W'(quo_w[i]);
      qv    = c7_d.neg[i] ? -qv : qv;
      sq[i] = sat_q16(qv);
    end
    sm = sat_q16(SUM_W'(c7_d.mag));
    unique case (c7_d.func) inside
      FN_DIV, FN_NORM: begin
        for (int i = 0; i < LANES; i++) begin
          c7_d.r[i] = sq[i].val;
          c7_d.ovf  = c7_d.ovf | sq[i].ovf;
        end
      end
      FN_PROJ: begin
        c7_d.r[0] = sq[0].val;
        c7_d.ovf  = c7_d.ovf | sq[0].ovf;
      end
      FN_MAG: begin
        c7_d.rs  = sm.val;
        c7_d.ovf = sm.ovf;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pf_d[i] = PROD_W'($signed(c7_q.r[0])) * PROD_W'($signed(c7_q.b[i]));
    end
  end

  always_comb begin
    sat_t sp [LANES];
    c9_d = c8_q;
    for (int i = 0; i < LANES; i++) begin
      sp[i] = sat_q16(rnd_q16(SUM_W'(pf_q[i])));
    end
    if (c8_q.func == FN_PROJ) begin
      c9_d.rs = '0;
      for (int i = 0; i < LANES; i++) begin
        c9_d.r[i] = sp[i].val;
        c9_d.ovf  = c9_d.ovf | sp[i].ovf;
      end
    end
    if (c8_q.err) begin
      c9_d.r   = '0;
      c9_d.rs  = '0;
      c9_d.ovf = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      c1_q <= c1_d;
      for (int k = 0; k < MULTS; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        p_q[k] <= PROD_W'(x_q[k]) * PROD_W'(y_q[k]);
      end
      c2_q <= c1_q;
      c3_q <= c2_q;
      for (int i = 0; i < LANES; i++) begin
        sum_q[i] <= sum_d[i];
        e_q[i]   <= e_d[i];
      end
      c4_q     <= c4_d;
      rad_q    <= sum_q[0][RAD_W-1:0];
      dsq_q[0] <= c4_q;
      for (int k = 1; k < SQ_STAGES; k++) begin
        dsq_q[k] <= dsq_q[k-1];
      end
      c5_q <= c5_d;
      c6_q <= c6_d;
      for (int i = 0; i < LANES; i++) begin
        nm_q[i] <= nm_d[i];
        dn_q[i] <= dn_d[i];
      end
      ddv_q[0] <= c6_q;
      for (int k = 1; k < DV_STAGES; k++) begin
        ddv_q[k] <= ddv_q[k-1];
      end
      c7_q <= c7_d;
      c8_q <= c7_q;
      for (int i = 0; i < LANES; i++) begin
        pf_q[i] <= pf_d[i];
      end
      c9_q <= c9_d;
    end
  end

  assign m_axis_tvalid = v9_q;
  assign m_axis_tdata  = {c9_q.rs, c9_q.r[2], c9_q.r[1], c9_q.r[0]};
  assign m_axis_tuser  = {c9_q.ovf, c9_q.err};

endmodule

// ----- hw/rtl/v3a_checker.sv -----
// ----------------------------------------------------------------------------
// Vector arithmetic unit checker
// Port-level assertions on the vector unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module v3a_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [v3a_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [v3a_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [v3a_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [v3a_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import v3a_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled result transaction changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("Input accepted while the output is stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
    else $error("Division error result is not all zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[4*Q_W-1:3*Q_W] != '0) |->
      (m_axis_tdata[3*Q_W-1:0] == '0))
    else $error("Scalar and vector results are both nonzero.");

endmodule

bind vector3_arithmetic_unit v3a_checker u_v3a_checker (.*);
